// ===== hdl/fscr_pkg.sv =====
// ----------------------------------------------------------------------------
// fscr_pkg
// Shared types and constants of the filtered score coverage rank block.
// ----------------------------------------------------------------------------
package fscr_pkg;

   // Stored set geometry
   localparam int DEPTH       = 1024;
   localparam int SCORE_WIDTH = 32;
   localparam int IDX_W       = $clog2(DEPTH);
   localparam int CNT_W       = $clog2(DEPTH + 1);
   localparam int FRAC_W      = 17;
   localparam int FRAC_STEPS  = FRAC_W;
   localparam int STEP_W      = $clog2(FRAC_STEPS);

   // Configuration register map
   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_GAP_MODE = 1'b0;

   // Item kinds
   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   // Gap filter modes
   localparam logic [2:0] GAP_KEEP_ALL    = 3'd0;
   localparam logic [2:0] GAP_DROP_SUNK   = 3'd1;
   localparam logic [2:0] GAP_DROP_ALLGAP = 3'd2;
   localparam logic [2:0] GAP_DROP_REFGAP = 3'd3;
   localparam logic [2:0] GAP_DROP_EITHER = 3'd4;

   // Fraction value for 1.0 in Q1.16
   localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;

   typedef struct packed {
      logic                          kind;
      logic                          start_set;
      logic signed [SCORE_WIDTH-1:0] score_value;
      logic                          is_all_gaps;
      logic                          ref_is_gap;
      logic                          is_sunk;
      logic [IDX_W-1:0]              query_index;
   } req_item_type;

   typedef struct packed {
      logic [CNT_W-1:0]  covered_count;
      logic [CNT_W-1:0]  set_size;
      logic [FRAC_W-1:0] coverage_fraction;
      logic              index_in_set;
   } rsp_item_type;

   // Query sequencer states
   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_TARGET = 4'b0010,
      ST_SCAN   = 4'b0100,
      ST_DIVIDE = 4'b1000
   } state_type;

   // Keep decision of one position under a gap mode
   function automatic logic position_kept(input logic [2:0] mode,
                                          input logic all_gap,
                                          input logic ref_gap,
                                          input logic sunk);
      logic keep;
      case (mode)
         GAP_DROP_SUNK:   keep = !sunk;
         GAP_DROP_ALLGAP: keep = !all_gap;
         GAP_DROP_REFGAP: keep = !ref_gap;
         GAP_DROP_EITHER: keep = !(all_gap || ref_gap);
         default:         keep = 1'b1;
      endcase
      return keep;
   endfunction

endpackage

// ===== hdl/filtered_score_coverage_rank.sv =====
// ----------------------------------------------------------------------------
// filtered_score_coverage_rank
// Keeps gap-filtered position scores in a score memory with one write and one
// read port and answers rank queries: count of kept scores <= the indexed one,
// set size and the Q1.16 fraction count/size.
// ----------------------------------------------------------------------------
// Operation: a load is written and counted at the edge that accepts it. A query on
// an index inside the set returns its result after one memory read for the
// target, one read per kept score through the single memory read port, then
// 17 steps of a bit-serial divider. A query outside the set answers in the cycle after the transfer.
// Throughput: one item at a time; busy stays high while a query runs.
// Reset clears the set size, the gap mode and the sequencer; score memory is
// not cleared. Results cannot be stalled by the receiver.
module filtered_score_coverage_rank (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  fscr_pkg::req_item_type                req_item,
   output logic                                  rsp_valid,
   output fscr_pkg::rsp_item_type                rsp_item,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [fscr_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [31:0]                           csr_pwdata,
   output logic [31:0]                           csr_prdata,
   output logic                                  csr_pready
);

   // Score memory
   logic signed [fscr_pkg::SCORE_WIDTH-1:0] score_mem [fscr_pkg::DEPTH];
   logic signed [fscr_pkg::SCORE_WIDTH-1:0] rd_data_ff;
   logic [fscr_pkg::IDX_W-1:0]              rd_addr;
   logic                                    wr_en;
   logic [fscr_pkg::IDX_W-1:0]              wr_addr;

   // Control and datapath registers
   fscr_pkg::state_type                     state_ff, state_in;
   logic [2:0]                              gap_mode_ff, gap_mode_in;
   logic [fscr_pkg::CNT_W-1:0]              kept_count_ff, kept_count_in;
   logic [fscr_pkg::CNT_W-1:0]              scan_addr_ff, scan_addr_in;
   logic [fscr_pkg::CNT_W-1:0]              count_ff, count_in;
   logic signed [fscr_pkg::SCORE_WIDTH-1:0] target_ff, target_in;
   logic [fscr_pkg::CNT_W:0]                rem_ff, rem_in;
   logic [fscr_pkg::FRAC_W-1:0]             quo_ff, quo_in;
   logic [fscr_pkg::STEP_W-1:0]             step_ff, step_in;
   logic                                    rsp_valid_ff, rsp_valid_in;
   fscr_pkg::rsp_item_type                  rsp_item_ff, rsp_item_in;

   logic                                    accept;
   logic                                    csr_write;
   logic [fscr_pkg::CNT_W-1:0]              base_count;
   logic                                    keep;
   logic [fscr_pkg::CNT_W-1:0]              count_next;
   logic                                    div_ge;
   logic [fscr_pkg::CNT_W:0]                rem_sub;

   assign accept     = start && !busy;
   assign busy       = (state_ff != fscr_pkg::ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_item   = rsp_item_ff;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Register read
   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == fscr_pkg::CSR_GAP_MODE) begin
         csr_prdata = {29'd0, gap_mode_ff};
      end
   end

   // Load path: base size after an optional restart, then append if kept
   assign base_count = req_item.start_set ? '0 : kept_count_ff;
   assign keep = fscr_pkg::position_kept(gap_mode_ff, req_item.is_all_gaps,
                                         req_item.ref_is_gap, req_item.is_sunk);
   assign wr_addr = base_count[fscr_pkg::IDX_W-1:0];
   assign wr_en = accept && (req_item.kind == fscr_pkg::KIND_LOAD) && keep &&
                  (base_count < fscr_pkg::CNT_W'(fscr_pkg::DEPTH));

   // Read address: query index when idle, scan pointer otherwise
   assign rd_addr = (state_ff == fscr_pkg::ST_IDLE) ? req_item.query_index
                                                    : scan_addr_ff[fscr_pkg::IDX_W-1:0];

   // Compare the returned score against the target
   assign count_next = count_ff + fscr_pkg::CNT_W'(rd_data_ff <= target_ff);

   // Divider step: restoring, one quotient bit per cycle
   assign div_ge  = (rem_ff >= {1'b0, kept_count_ff});
   assign rem_sub = div_ge ? (rem_ff - {1'b0, kept_count_ff}) : rem_ff;

   always_comb begin
      state_in      = state_ff;
      gap_mode_in   = gap_mode_ff;
      kept_count_in = kept_count_ff;
      scan_addr_in  = scan_addr_ff;
      count_in      = count_ff;
      target_in     = target_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      step_in       = step_ff;
      rsp_valid_in  = 1'b0;
      rsp_item_in   = rsp_item_ff;

      if (csr_write && (csr_paddr[2] == fscr_pkg::CSR_GAP_MODE)) begin
         gap_mode_in = csr_pwdata[2:0];
      end

      unique case (state_ff)
         fscr_pkg::ST_IDLE: begin
            if (accept && (req_item.kind == fscr_pkg::KIND_LOAD)) begin
               kept_count_in = wr_en ? (base_count + 1'b1) : base_count;
            end else if (accept) begin
               if ({1'b0, req_item.query_index} < kept_count_ff) begin
                  state_in     = fscr_pkg::ST_TARGET;
                  scan_addr_in = '0;
                  count_in     = '0;
               end else begin
                  // Outside the set: answer at once
                  rsp_valid_in                  = 1'b1;
                  rsp_item_in.covered_count     = '0;
                  rsp_item_in.set_size          = kept_count_ff;
                  rsp_item_in.coverage_fraction = fscr_pkg::FRAC_ONE;
                  rsp_item_in.index_in_set      = 1'b0;
               end
            end
         end
         fscr_pkg::ST_TARGET: begin
            // Capture target, issue first scan read
            target_in    = rd_data_ff;
            scan_addr_in = scan_addr_ff + 1'b1;
            state_in     = fscr_pkg::ST_SCAN;
         end
         fscr_pkg::ST_SCAN: begin
            count_in = count_next;
            if (scan_addr_ff == kept_count_ff) begin
               state_in = fscr_pkg::ST_DIVIDE;
               rem_in   = {1'b0, count_next};
               quo_in   = '0;
               step_in  = '0;
            end else begin
               scan_addr_in = scan_addr_ff + 1'b1;
            end
         end
         fscr_pkg::ST_DIVIDE: begin
            rem_in  = {rem_sub[fscr_pkg::CNT_W-1:0], 1'b0};
            quo_in  = {quo_ff[fscr_pkg::FRAC_W-2:0], div_ge};
            step_in = step_ff + 1'b1;
            if (step_ff == fscr_pkg::STEP_W'(fscr_pkg::FRAC_STEPS - 1)) begin
               state_in                      = fscr_pkg::ST_IDLE;
               rsp_valid_in                  = 1'b1;
               rsp_item_in.covered_count     = count_ff;
               rsp_item_in.set_size          = kept_count_ff;
               rsp_item_in.coverage_fraction = {quo_ff[fscr_pkg::FRAC_W-2:0], div_ge};
               rsp_item_in.index_in_set      = 1'b1;
            end
         end
         default: begin
            state_in = fscr_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= fscr_pkg::ST_IDLE;
         gap_mode_ff   <= fscr_pkg::GAP_KEEP_ALL;
         kept_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         gap_mode_ff   <= gap_mode_in;
         kept_count_ff <= kept_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      scan_addr_ff <= scan_addr_in;
      count_ff     <= count_in;
      target_ff    <= target_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      step_ff      <= step_in;
      rsp_item_ff  <= rsp_item_in;
   end

   // Score memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         score_mem[wr_addr] <= req_item.score_value;
      end
      rd_data_ff <= score_mem[rd_addr];
   end

   // Checks
   a_size_bound: assert property (@(posedge clock) disable iff (reset)
      kept_count_ff <= fscr_pkg::CNT_W'(fscr_pkg::DEPTH))
      else $error("set size above depth");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fscr_pkg::ST_SCAN) |->
         (scan_addr_ff <= kept_count_ff) && (scan_addr_ff != '0))
      else $error("scan pointer outside set");

   a_rank_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.index_in_set) |->
         (rsp_item.covered_count != '0) &&
         (rsp_item.covered_count <= rsp_item.set_size))
      else $error("covered count outside set");

   a_size_frozen: assert property (@(posedge clock) disable iff (reset)
      (busy && $past(busy)) |-> $stable(kept_count_ff))
      else $error("set size changed during query");

endmodule
